// ----- rtl/core/srff_pkg.sv -----
package srff_pkg;

    // Field widths
    localparam int DIST_W = 16;
    localparam int TIME_W = 32;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_DIST  = 3'd0;
    localparam logic [2:0] CFG_MAX_DIST  = 3'd1;
    localparam logic [2:0] CFG_FAULT_THR = 3'd2;
    localparam logic [2:0] CFG_FILT_LEN  = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd4;

    // Raw ring and fallback window
    localparam int RAW_DEPTH      = 10;
    localparam int RAW_IDX_W      = 4;
    localparam int FALLBACK_COUNT = 5;
    localparam int RANGE_MARGIN   = 10;

    // Moving-average store
    localparam int MA_DEPTH = 16;
    localparam int MA_IDX_W = (MA_DEPTH > 1) ? $clog2(MA_DEPTH) : 1;
    localparam int LEN_W    = $clog2(MA_DEPTH + 1);

    // Mean unit sizing: largest term count, divisor and sum widths
    localparam int MAX_TERMS = (MA_DEPTH > RAW_DEPTH) ? MA_DEPTH : RAW_DEPTH;
    localparam int DIVR_W    = $clog2(MAX_TERMS + 1);
    localparam int SUM_W     = DIST_W + DIVR_W;

    // Divider retires two quotient bits per cycle
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/srff_div.sv -----
module srff_div
    import srff_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DIVR_W-1:0]    r_rem;
    logic [DIVR_W-1:0]    r_dvs;

    logic [DIV_W-1:0]     n_quo;
    logic [DIVR_W-1:0]    n_rem;

    // Two restoring steps per cycle; remainder stays below the divisor
    always_comb begin
        logic [DIVR_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem    = DIVR_W'(trial - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[DIVR_W-1:0];
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= DIV_W'(i_req.dividend);
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[DIST_W-1:0];

endmodule

// ----- rtl/core/sonar_range_fault_filter.sv -----
// Sonar range qualifier and smoothing filter. Each request is either a distance
// sample or a timeout tick; each produces exactly one result. A request that needs
// no mean (ticks, startup samples that do not end the startup run, faults without
// fallback) goes straight to the final state, which loads its result into the
// output register; the block then returns to idle and takes the next request. A
// request that takes a rounded mean over n stored entries (n = 10 at startup, 5
// for fault fallback, or the filter length) passes through the shared accumulator
// one entry per cycle, starts the two-bits-per-cycle divider, waits for its done,
// loads the output register and returns to idle. A mean whose entries are all zero
// skips the divider. A result still waiting in the output register holds the next
// one back. The block holds o_stall high for the whole request and accepts the next
// one once the result has moved into the output register. Configuration writes are
// always taken and must only be issued while the block is idle.
module sonar_range_fault_filter
    import srff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [DIST_W-1:0] i_distance_mm,
    input  logic [TIME_W-1:0] i_timestamp_us,
    // Result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_published,
    output logic [DIST_W-1:0] o_filtered_mm,
    output logic              o_sample_accepted,
    output logic              o_ready_res,
    output logic [DIST_W-1:0] o_estimate_mm,
    output logic              o_timed_out,
    // Configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [1:0] MEAN_INIT     = 2'd0;
    localparam logic [1:0] MEAN_FALLBACK = 2'd1;
    localparam logic [1:0] MEAN_AVG      = 2'd2;

    localparam logic [3:0] VC_MAX   = 4'd15;
    localparam logic [3:0] VC_READY = 4'd10;
    localparam logic [1:0] FR_MAX   = 2'd3;

    // Configuration registers
    logic [DIST_W-1:0] r_min_dist, r_max_dist, r_fault_thr;
    logic [4:0]        r_filt_len;
    logic [TIME_W-1:0] r_timeout;

    // Filter state
    logic [DIST_W-1:0]    r_raw [RAW_DEPTH];
    logic [RAW_IDX_W-1:0] r_ri, n_ri;
    logic [DIST_W-1:0]    r_ma [MA_DEPTH];
    logic [MA_IDX_W-1:0]  r_ai, n_ai;
    logic [DIST_W-1:0]    r_est, n_est;
    logic                 r_ready, n_ready;
    logic [3:0]           r_vc, n_vc;
    logic [1:0]           r_fr, n_fr;
    logic [TIME_W-1:0]    r_lvt, n_lvt;

    // Sequencer and accumulator
    logic [1:0]        r_state, n_state;
    logic [1:0]        r_kind, n_kind;
    logic [DIVR_W-1:0] r_term, n_term;
    logic [DIVR_W-1:0] r_nterms, n_nterms;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_nz, n_nz;

    // Per-request result flags
    logic              r_pub, n_pub;
    logic [DIST_W-1:0] r_filt, n_filt;
    logic              r_acc, n_acc;
    logic              r_tout_hit, n_tout_hit;

    // Output register
    logic              r_out_valid;
    logic              r_res_pub, r_res_acc, r_res_ready, r_res_tout;
    logic [DIST_W-1:0] r_res_filt, r_res_est;

    logic              raw_we, ma_we;
    logic [DIST_W-1:0] term;
    logic [LEN_W-1:0]  len;
    logic              out_load;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    srff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    // Effective moving-average length, clamped to 1..MA_DEPTH
    always_comb begin
        if (r_filt_len == 5'd0) begin
            len = LEN_W'(1);
        end else if (32'(r_filt_len) > MA_DEPTH) begin
            len = LEN_W'(MA_DEPTH);
        end else begin
            len = LEN_W'(r_filt_len);
        end
    end

    // Entry under the accumulator
    always_comb begin
        if (r_kind == MEAN_AVG) begin
            term = r_ma[r_term[MA_IDX_W-1:0]];
        end else if (32'(r_term) < RAW_DEPTH) begin
            term = r_raw[r_term[RAW_IDX_W-1:0]];
        end else begin
            term = '0;
        end
    end

    // Sequencer
    always_comb begin
        logic [DIST_W:0]      lo_lim;
        logic                 in_rng;
        logic [DIST_W-1:0]    dev;
        logic                 ok;
        logic [RAW_IDX_W:0]   ri_inc;
        logic [MA_IDX_W:0]    ai_inc;
        logic [3:0]           vc_inc;
        logic [TIME_W-1:0]    since;

        n_state    = r_state;
        n_kind     = r_kind;
        n_term     = r_term;
        n_nterms   = r_nterms;
        n_sum      = r_sum;
        n_nz       = r_nz;
        n_ri       = r_ri;
        n_ai       = r_ai;
        n_est      = r_est;
        n_ready    = r_ready;
        n_vc       = r_vc;
        n_fr       = r_fr;
        n_lvt      = r_lvt;
        n_pub      = r_pub;
        n_filt     = r_filt;
        n_acc      = r_acc;
        n_tout_hit = r_tout_hit;
        raw_we     = 1'b0;
        ma_we      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_sum;
        div_req.divisor  = r_nterms;

        lo_lim = {1'b0, r_min_dist} + (DIST_W+1)'(RANGE_MARGIN);
        in_rng = ({1'b0, i_distance_mm} >= lo_lim) &&
                 (({1'b0, i_distance_mm} + (DIST_W+1)'(RANGE_MARGIN)) <= {1'b0, r_max_dist});
        dev    = (i_distance_mm > r_est) ? (i_distance_mm - r_est) : (r_est - i_distance_mm);
        ok     = in_rng && (dev <= r_fault_thr);
        ri_inc = {1'b0, r_ri} + (RAW_IDX_W+1)'(1);
        ai_inc = {1'b0, r_ai} + (MA_IDX_W+1)'(1);
        vc_inc = (r_vc < VC_MAX) ? (r_vc + 4'd1) : r_vc;
        since  = i_timestamp_us - r_lvt;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_pub      = 1'b0;
                    n_filt     = '0;
                    n_acc      = 1'b0;
                    n_tout_hit = 1'b0;
                    n_state    = ST_FIN;
                    n_term     = '0;
                    n_nz       = 1'b0;
                    if (i_req_type == REQ_TICK) begin
                        // Timeout tick
                        if ((since > r_timeout) && r_ready) begin
                            n_ready    = 1'b0;
                            n_vc       = '0;
                            n_tout_hit = 1'b1;
                        end
                    end else if (!r_ready) begin
                        // Startup: fill the raw ring with in-range samples
                        if (r_vc <= 4'd1) begin
                            n_est = i_distance_mm;
                        end
                        if (!in_rng) begin
                            n_vc = '0;
                        end else begin
                            n_acc  = 1'b1;
                            n_vc   = vc_inc;
                            n_lvt  = i_timestamp_us;
                            raw_we = (32'(r_ri) < RAW_DEPTH);
                            n_ri   = (ri_inc > (RAW_IDX_W+1)'(RAW_DEPTH - 1)) ?
                                     '0 : ri_inc[RAW_IDX_W-1:0];
                            if (vc_inc > VC_READY) begin
                                n_kind   = MEAN_INIT;
                                n_nterms = DIVR_W'(RAW_DEPTH);
                                n_sum    = SUM_W'(RAW_DEPTH / 2);
                                n_state  = ST_SUM;
                            end
                        end
                    end else begin
                        // Running: fault check against the estimate
                        if (in_rng) begin
                            n_vc  = vc_inc;
                            n_lvt = i_timestamp_us;
                        end
                        raw_we = (32'(r_ri) < RAW_DEPTH);
                        n_ri   = (ri_inc > (RAW_IDX_W+1)'(FALLBACK_COUNT - 1)) ?
                                 '0 : ri_inc[RAW_IDX_W-1:0];
                        if (!ok) begin
                            if (r_fr == FR_MAX) begin
                                n_kind   = MEAN_FALLBACK;
                                n_nterms = DIVR_W'(FALLBACK_COUNT);
                                n_sum    = SUM_W'(FALLBACK_COUNT / 2);
                                n_state  = ST_SUM;
                            end
                            if (r_fr < FR_MAX) begin
                                n_fr = r_fr + 2'd1;
                            end
                        end else begin
                            n_acc    = 1'b1;
                            n_fr     = '0;
                            ma_we    = 1'b1;
                            n_ai     = (32'(ai_inc) >= 32'(len)) ?
                                       '0 : ai_inc[MA_IDX_W-1:0];
                            n_kind   = MEAN_AVG;
                            n_nterms = DIVR_W'(len);
                            n_sum    = SUM_W'(len >> 1);
                            n_state  = ST_SUM;
                        end
                    end
                end
            end
            ST_SUM: begin
                // One entry per cycle into the accumulator, then divide, or finish when all entries are zero
                if (r_term != r_nterms) begin
                    n_sum  = r_sum + SUM_W'(term);
                    n_nz   = r_nz | (term != '0);
                    n_term = r_term + DIVR_W'(1);
                end else if (r_nz) begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_est = div_rsp.quotient;
                    if (r_kind == MEAN_INIT) begin
                        n_ready = 1'b1;
                    end
                    if (r_kind == MEAN_AVG) begin
                        n_pub  = 1'b1;
                        n_filt = div_rsp.quotient;
                    end
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= 16'd200;
            r_max_dist  <= 16'd4000;
            r_fault_thr <= 16'd148;
            r_filt_len  <= 5'd5;
            r_timeout   <= 32'd1000000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_data[DIST_W-1:0];
                CFG_FAULT_THR: r_fault_thr <= i_cfg_data[DIST_W-1:0];
                CFG_FILT_LEN:  r_filt_len  <= i_cfg_data[4:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Filter state and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RAW_DEPTH; i++) begin
                r_raw[i] <= '0;
            end
            for (int i = 0; i < MA_DEPTH; i++) begin
                r_ma[i] <= '0;
            end
            r_ri       <= '0;
            r_ai       <= '0;
            r_est      <= '0;
            r_ready    <= 1'b0;
            r_vc       <= '0;
            r_fr       <= '0;
            r_lvt      <= '0;
            r_state    <= ST_IDLE;
            r_kind     <= MEAN_INIT;
            r_term     <= '0;
            r_nterms   <= '0;
            r_sum      <= '0;
            r_nz       <= 1'b0;
            r_pub      <= 1'b0;
            r_filt     <= '0;
            r_acc      <= 1'b0;
            r_tout_hit <= 1'b0;
        end else begin
            if (raw_we) begin
                r_raw[r_ri] <= i_distance_mm;
            end
            if (ma_we) begin
                r_ma[r_ai] <= i_distance_mm;
            end
            r_ri       <= n_ri;
            r_ai       <= n_ai;
            r_est      <= n_est;
            r_ready    <= n_ready;
            r_vc       <= n_vc;
            r_fr       <= n_fr;
            r_lvt      <= n_lvt;
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_term     <= n_term;
            r_nterms   <= n_nterms;
            r_sum      <= n_sum;
            r_nz       <= n_nz;
            r_pub      <= n_pub;
            r_filt     <= n_filt;
            r_acc      <= n_acc;
            r_tout_hit <= n_tout_hit;
        end
    end

    // Output register: valid is control, fields are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res_pub   <= r_pub;
            r_res_filt  <= r_filt;
            r_res_acc   <= r_acc;
            r_res_ready <= r_ready;
            r_res_est   <= r_est;
            r_res_tout  <= r_tout_hit;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_published       = r_res_pub;
    assign o_filtered_mm     = r_res_filt;
    assign o_sample_accepted = r_res_acc;
    assign o_ready_res       = r_res_ready;
    assign o_estimate_mm     = r_res_est;
    assign o_timed_out       = r_res_tout;

`ifndef NO_ASSERTIONS
    // Divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without entering busy state");

    // Raw ring index stays inside the ring
    a_ring_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ri) < RAW_DEPTH)
        else $error("raw ring index out of range");

    // A published average only comes from an accepted sample while ready
    a_pub_implies_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_published) |-> (o_sample_accepted && o_ready_res))
        else $error("published result without accepted sample or ready");
`endif

endmodule

// ----- tb/sv/sonar_range_fault_filter_tb.sv -----
`timescale 1ns / 100ps

module sonar_range_fault_filter_tb
    import srff_pkg::*;
();

    // Index with no register behind it
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic              kind;
        logic [DIST_W-1:0] distance;
        logic [TIME_W-1:0] stamp;
    } t_sonar_req;

    // Field order: published, filtered, accepted, ready, estimate, timed_out
    typedef struct packed {
        logic              published;
        logic [DIST_W-1:0] filtered_mm;
        logic              sample_accepted;
        logic              ready_res;
        logic [DIST_W-1:0] estimate_mm;
        logic              timed_out;
    } t_filter_result;

    typedef struct packed {
        t_sonar_req     req;
        logic           typed;
        t_filter_result want;
    } t_directed_row;

    typedef struct packed {
        logic [31:0] min_mm;
        logic [31:0] max_mm;
        logic [31:0] thresh_mm;
        logic [31:0] length;
        logic [31:0] timeout;
    } t_setting;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT  = 4000;

    // DUT ports
    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_req_type;
    logic [DIST_W-1:0] i_distance_mm;
    logic [TIME_W-1:0] i_timestamp_us;
    logic              o_valid;
    logic              i_stall;
    logic              o_published;
    logic [DIST_W-1:0] o_filtered_mm;
    logic              o_sample_accepted;
    logic              o_ready_res;
    logic [DIST_W-1:0] o_estimate_mm;
    logic              o_timed_out;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [31:0]       i_cfg_data;

    sonar_range_fault_filter uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_distance_mm     (i_distance_mm),
        .i_timestamp_us    (i_timestamp_us),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_published       (o_published),
        .o_filtered_mm     (o_filtered_mm),
        .o_sample_accepted (o_sample_accepted),
        .o_ready_res       (o_ready_res),
        .o_estimate_mm     (o_estimate_mm),
        .o_timed_out       (o_timed_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Filter state mirror
    logic [DIST_W-1:0] cfg_min, cfg_max, cfg_thresh;
    logic [4:0]        cfg_len;
    logic [TIME_W-1:0] cfg_timeout;
    logic [DIST_W-1:0] raw_ring [RAW_DEPTH];
    logic [DIST_W-1:0] avg_ring [MA_DEPTH];
    int unsigned       raw_pos, avg_pos, valid_run, fault_run;
    logic [DIST_W-1:0] estimate_q;
    logic              est_ready;
    logic [TIME_W-1:0] last_valid_us;

    t_filter_result pending_filter_results [$];
    t_directed_row  directed_rows [$];
    t_setting       phase_settings [NUM_PHASES];

    int unsigned tx_idle_pct, rx_idle_pct;
    int unsigned pressure_requests;
    int unsigned mismatch_total, idle_cycles;
    int unsigned n_requests, n_published, n_rejected, n_timeouts;
    int          base_mm;
    logic [TIME_W-1:0] clock_us;
    t_filter_result got, want;

    function automatic logic [DIST_W-1:0] rounded_mean(input int unsigned sum,
                                                      input int unsigned n);
        int unsigned q;
        q = (sum + n / 2) / n;
        return q[DIST_W-1:0];
    endfunction

    function automatic bit distance_in_range(input logic [DIST_W-1:0] d);
        int unsigned dd, lo, hi;
        dd = d;
        lo = cfg_min;
        hi = cfg_max;
        return (dd >= lo + RANGE_MARGIN) && (dd + RANGE_MARGIN <= hi);
    endfunction

    // Expected result of one request; advances the mirrored state
    function automatic t_filter_result predict_filter_result(input t_sonar_req req);
        t_filter_result    res;
        logic [TIME_W-1:0] elapsed;
        int unsigned       d, est, dev, sum, len;
        bit                passed;
        res = '0;
        d   = req.distance;
        if (req.kind == REQ_TICK) begin
            elapsed = req.stamp - last_valid_us;
            if (elapsed > cfg_timeout && est_ready) begin
                est_ready     = 1'b0;
                valid_run     = 0;
                res.timed_out = 1'b1;
                n_timeouts++;
            end
        end else if (!est_ready) begin
            // startup: fill the raw ring until more than ten in a row
            if (valid_run <= 1) estimate_q = req.distance;
            if (!distance_in_range(req.distance)) begin
                valid_run = 0;
            end else begin
                res.sample_accepted = 1'b1;
                if (valid_run < 15) valid_run++;
                last_valid_us = req.stamp;
                if (raw_pos < RAW_DEPTH) raw_ring[raw_pos] = req.distance;
                raw_pos++;
                if (raw_pos > RAW_DEPTH - 1) raw_pos = 0;
                if (valid_run > 10) begin
                    sum = 0;
                    for (int i = 0; i < RAW_DEPTH; i++) sum += raw_ring[i];
                    if (sum > 0) begin
                        estimate_q = rounded_mean(sum, RAW_DEPTH);
                        est_ready  = 1'b1;
                    end
                end
            end
        end else begin
            passed = 1'b0;
            if (distance_in_range(req.distance)) begin
                est = estimate_q;
                dev = (d > est) ? d - est : est - d;
                if (valid_run < 15) valid_run++;
                last_valid_us = req.stamp;
                passed = (dev <= cfg_thresh);
            end
            if (raw_pos < RAW_DEPTH) raw_ring[raw_pos] = req.distance;
            raw_pos++;
            if (raw_pos > FALLBACK_COUNT - 1) raw_pos = 0;
            if (!passed) begin
                // fault: after a run of three, fall back to the raw mean
                n_rejected++;
                if (fault_run > 2) begin
                    sum = 0;
                    for (int i = 0; i < FALLBACK_COUNT; i++) sum += raw_ring[i];
                    if (sum > 0) estimate_q = rounded_mean(sum, FALLBACK_COUNT);
                end
                if (fault_run < 3) fault_run++;
            end else begin
                len = cfg_len;
                if (len < 1) len = 1;
                if (len > MA_DEPTH) len = MA_DEPTH;
                res.sample_accepted = 1'b1;
                fault_run = 0;
                if (avg_pos < MA_DEPTH) avg_ring[avg_pos] = req.distance;
                avg_pos++;
                if (avg_pos >= len) avg_pos = 0;
                sum = 0;
                for (int i = 0; i < len; i++) sum += avg_ring[i];
                if (sum > 0) begin
                    res.filtered_mm = rounded_mean(sum, len);
                    res.published   = 1'b1;
                    estimate_q      = res.filtered_mm;
                    n_published++;
                end
            end
        end
        res.ready_res   = est_ready;
        res.estimate_mm = estimate_q;
        return res;
    endfunction

    task automatic add_row(input logic kind, input logic [DIST_W-1:0] mm,
                           input logic [TIME_W-1:0] stamp, input logic typed,
                           input t_filter_result typed_res);
        t_directed_row row;
        row.req.kind     = kind;
        row.req.distance = mm;
        row.req.stamp    = stamp;
        row.typed        = typed;
        row.want         = typed_res;
        directed_rows.push_back(row);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_DIST:  cfg_min     = data[DIST_W-1:0];
            CFG_MAX_DIST:  cfg_max     = data[DIST_W-1:0];
            CFG_FAULT_THR: cfg_thresh  = data[DIST_W-1:0];
            CFG_FILT_LEN:  cfg_len     = data[4:0];
            CFG_TIMEOUT:   cfg_timeout = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Offer one request, wait for acceptance, record its expected result
    task automatic send_request(input t_sonar_req req, input logic typed,
                                input t_filter_result typed_res);
        t_filter_result model_res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_req_type     = req.kind;
        i_distance_mm  = req.distance;
        i_timestamp_us = req.stamp;
        do @(posedge i_clk); while (o_stall);
        model_res = predict_filter_result(req);
        pending_filter_results.push_back(typed ? typed_res : model_res);
        n_requests++;
    endtask

    // Mostly well-formed runs around a base distance, plus faults, noise and ticks
    task automatic make_random_request(output t_sonar_req req);
        int          lo_s, hi_s, cand_mm, off, span;
        int unsigned pick;
        lo_s = cfg_min;
        lo_s = lo_s + RANGE_MARGIN;
        hi_s = cfg_max;
        hi_s = hi_s - RANGE_MARGIN;
        if (lo_s <= hi_s &&
            (base_mm < lo_s || base_mm > hi_s || $urandom_range(0, 29) == 0)) begin
            base_mm = $urandom_range(lo_s, hi_s);
        end
        if ($urandom_range(0, 49) == 0) clock_us = $urandom;
        else clock_us = clock_us + $urandom_range(1, 2000);
        pick         = $urandom_range(0, 99);
        req.kind     = REQ_SAMPLE;
        req.distance = $urandom;
        if (pick < 8) begin
            req.kind = REQ_TICK;
            if (pick < 4) clock_us = clock_us + cfg_timeout + 1 + $urandom_range(0, 1000);
        end else if (pick >= 16 && lo_s <= hi_s) begin
            span = cfg_thresh / 2;
            if (span > 100) span = 100;
            if (pick < 24) begin
                off = cfg_thresh + 1 + $urandom_range(0, 300);
                cand_mm = $urandom_range(0, 1) ? base_mm + off : base_mm - off;
            end else begin
                cand_mm = base_mm + int'($urandom_range(0, 2 * span)) - span;
            end
            if (cand_mm < lo_s) cand_mm = lo_s;
            if (cand_mm > hi_s) cand_mm = hi_s;
            req.distance = cand_mm[DIST_W-1:0];
        end
        req.stamp = clock_us;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_total++;
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result receiver stall, with an optional long hold-off
    initial begin
        int unsigned holds_done;
        int unsigned hold_left;
        holds_done = 0;
        hold_left  = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done != pressure_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else begin
                i_stall = ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_published, o_filtered_mm, o_sample_accepted,
                   o_ready_res, o_estimate_mm, o_timed_out};
            if (pending_filter_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_total++;
            end else begin
                want = pending_filter_results.pop_front();
                check_field("published", want.published, got.published);
                check_field("filtered_mm", want.filtered_mm, got.filtered_mm);
                check_field("sample_accepted", want.sample_accepted, got.sample_accepted);
                check_field("ready_res", want.ready_res, got.ready_res);
                check_field("estimate_mm", want.estimate_mm, got.estimate_mm);
                check_field("timed_out", want.timed_out, got.timed_out);
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence
    initial begin
        t_sonar_req req;
        mismatch_total    = 0;
        idle_cycles       = 0;
        n_requests        = 0;
        n_published       = 0;
        n_rejected        = 0;
        n_timeouts        = 0;
        pressure_requests = 0;
        base_mm           = 0;
        clock_us          = '0;
        tx_idle_pct       = 10;
        rx_idle_pct       = 60;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_req_type        = REQ_SAMPLE;
        i_distance_mm     = '0;
        i_timestamp_us    = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_MIN_DIST;
        i_cfg_data        = '0;

        // mirror state after reset
        cfg_min       = 16'd200;
        cfg_max       = 16'd4000;
        cfg_thresh    = 16'd148;
        cfg_len       = 5'd5;
        cfg_timeout   = 32'd1000000;
        raw_pos       = 0;
        avg_pos       = 0;
        valid_run     = 0;
        fault_run     = 0;
        estimate_q    = '0;
        est_ready     = 1'b0;
        last_valid_us = '0;
        foreach (raw_ring[i]) raw_ring[i] = '0;
        foreach (avg_ring[i]) avg_ring[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests on the reset settings
        add_row(REQ_TICK,   16'd0,     32'd0,  1'b1, {1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0});
        add_row(REQ_SAMPLE, 16'd0,     32'd10, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0});
        add_row(REQ_SAMPLE, 16'hFFFF,  32'd20, 1'b1,
                {1'b0, 16'd0, 1'b0, 1'b0, 16'hFFFF, 1'b0});
        // range edges: exactly min+10, exactly max-10, one past each
        add_row(REQ_SAMPLE, 16'd210,   32'd30, 1'b1, {1'b0, 16'd0, 1'b1, 1'b0, 16'd210, 1'b0});
        add_row(REQ_SAMPLE, 16'd3990,  32'd40, 1'b1, {1'b0, 16'd0, 1'b1, 1'b0, 16'd3990, 1'b0});
        add_row(REQ_SAMPLE, 16'd209,   32'd50, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0, 16'd3990, 1'b0});
        add_row(REQ_SAMPLE, 16'd3991,  32'd60, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0, 16'd3991, 1'b0});
        // eleven in a row to finish startup
        for (int k = 0; k < 11; k++)
            add_row(REQ_SAMPLE, 16'd995 + 16'(k % 3) * 16'd5, 32'd1000 + 32'(k) * 32'd1000,
                    1'b0, '0);
        add_row(REQ_SAMPLE, 16'd1020,  32'd13000, 1'b0, '0);
        // four faults in a row: the last one takes the fallback mean
        for (int k = 0; k < 4; k++)
            add_row(REQ_SAMPLE, 16'd2000, 32'd14000 + 32'(k) * 32'd1000, 1'b0, '0);
        add_row(REQ_SAMPLE, 16'd50,    32'd19000, 1'b0, '0);
        add_row(REQ_TICK,   16'd0,     32'd5000000, 1'b0, '0);

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

        // Register settings per random phase: reset values, then extremes, then random ones
        phase_settings[0] = '{32'd200,   32'd4000,  32'd148,   32'd5,  32'd1000000};
        phase_settings[1] = '{32'd0,     32'd65535, 32'd65535, 32'd16, 32'hFFFF_FFFF};
        phase_settings[2] = '{32'd500,   32'd1500,  32'd0,     32'd1,  32'd0};
        phase_settings[3] = '{32'd100,   32'd3000,  32'd60,    32'd0,  32'd20000};
        phase_settings[4] = '{32'd65535, 32'd65535, 32'd100,   32'd31, 32'd50000};
        phase_settings[5] = '{32'd0,     32'd5,     32'd200,   32'd7,  32'd1000};
        phase_settings[6] = '{$urandom_range(0, 1000), $urandom_range(2000, 65535),
                              $urandom_range(1, 400), $urandom_range(0, 31), $urandom};
        phase_settings[7] = '{$urandom, $urandom, $urandom, $urandom, $urandom};

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // registers change only with nothing in flight
            @(negedge i_clk);
            i_valid = 1'b0;
            while (pending_filter_results.size() != 0) @(posedge i_clk);
            write_register(CFG_MIN_DIST, phase_settings[phase].min_mm);
            write_register(CFG_MAX_DIST, phase_settings[phase].max_mm);
            write_register(CFG_FAULT_THR, phase_settings[phase].thresh_mm);
            write_register(CFG_FILT_LEN, phase_settings[phase].length);
            write_register(CFG_TIMEOUT, phase_settings[phase].timeout);
            if (phase == NUM_PHASES - 1) write_register(CFG_UNUSED_IDX, $urandom);

            if (phase < 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 60;
            end else if (phase < 6) begin
                tx_idle_pct = 60;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ((phase == 1 || phase == 4) && n == 40) pressure_requests++;
                make_random_request(req);
                send_request(req, 1'b0, '0);
            end
        end

        // Drain, then watch for stray results
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_filter_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests over %0d register settings plus directed edge cases.",
                 n_requests, NUM_PHASES);
        $display("Saw %0d published averages, %0d rejected samples, %0d timeout clears.",
                 n_published, n_rejected, n_timeouts);
        if (mismatch_total == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/srff_pkg.sv
rtl/core/srff_div.sv
rtl/core/sonar_range_fault_filter.sv
tb/sv/sonar_range_fault_filter_tb.sv
